[rtl/tlptw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Page table walker package
// Types and constants shared by the walker, its sequencer and its testbench.
// ----------------------------------------------------------------------------
package tlptw_pkg;

  // table store geometry
  localparam int TableWords = 4096;
  localparam int TableIdxW  = $clog2(TableWords);
  localparam int WordIdxW   = 30;  // word index of a 32-bit byte address

  localparam int BitPresent = 0;
  localparam int BitBig     = 7;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_XLATE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FAULT = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    WS_IDLE,
    WS_DIR,
    WS_TBL
  } walk_state_e;

  typedef struct packed {
    status_e     status;
    logic [31:0] physical_address;
    logic [31:0] entry_value;
    logic        big_page;
  } result_t;

endpackage : tlptw_pkg
`default_nettype wire

[rtl/tlptw_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Page table walker channels
// Request, response and configuration write channels (valid/ready).
// ----------------------------------------------------------------------------
interface tlptw_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] address;
  logic [31:0] data;

  modport source (output valid, command, address, data, input ready);
  modport sink   (input valid, command, address, data, output ready);
endinterface : tlptw_req_if

interface tlptw_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] physical_address;
  logic [31:0] entry_value;
  logic        big_page;

  modport source (output valid, status, physical_address, entry_value, big_page,
                  input ready);
  modport sink   (input valid, status, physical_address, entry_value, big_page,
                  output ready);
endinterface : tlptw_rsp_if

interface tlptw_cfg_if;
  logic        valid;
  logic        ready;
  logic [19:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface : tlptw_cfg_if
`default_nettype wire

[rtl/two_level_page_table_walker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Two-level page table walker
// i386-style 32-bit walk (4 KB and 4 MB pages) over a local table store.
// ----------------------------------------------------------------------------
//  channel | dir | words carried
//  --------+-----+---------------------------------------------------
//  req_i   | in  | command, address, data
//  rsp_o   | out | status, physical_address, entry_value, big_page
//  cfg_i   | in  | data = directory base frame (20 bits)
//
//  Write word, translate with directory out of store: response set on accept;
//  else from WS_DIR (fault, 4 MB page, table out of store) or WS_TBL (full
//  walk); the dependent reads of the single-port store with registered read
//  set this. One word in flight; req_i is ready when idle and the response
//  slot is free or being drained. Store undefined after reset, no clear.
// ----------------------------------------------------------------------------
module two_level_page_table_walker
  import tlptw_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tlptw_req_if.sink   req_i,
  tlptw_rsp_if.source rsp_o,
  tlptw_cfg_if.sink   cfg_i
);

  logic [19:0]          dir_base_q, dir_base_d;
  logic                 ram_we;
  logic                 ram_re;
  logic [TableIdxW-1:0] ram_addr;
  logic [31:0]          ram_wdata;
  logic [31:0]          ram_rdata;

  assign cfg_i.ready = 1'b1;
  assign dir_base_d  = (cfg_i.valid && cfg_i.ready) ? cfg_i.data : dir_base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_base_q <= '0;
    end else begin
      dir_base_q <= dir_base_d;
    end
  end

  tlptw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dir_base_i  (dir_base_q),
    .req         (req_i),
    .rsp         (rsp_o),
    .ram_we_o    (ram_we),
    .ram_re_o    (ram_re),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata)
  );

  tlptw_ram #(
    .Width (32),
    .Depth (TableWords)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

endmodule : two_level_page_table_walker
`default_nettype wire

[rtl/tlptw_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module tlptw_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : tlptw_ram
`default_nettype wire

[rtl/tlptw_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Page table walker sequencer
// Walks directory and table through one store port, one index compare shared
// by both levels and by word writes, and holds the response register.
// ----------------------------------------------------------------------------
module tlptw_ctrl
  import tlptw_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [19:0]      dir_base_i,
  tlptw_req_if.sink             req,
  tlptw_rsp_if.source           rsp,
  output      logic             ram_we_o,
  output      logic             ram_re_o,
  output      logic [TableIdxW-1:0] ram_addr_o,
  output      logic [31:0]      ram_wdata_o,
  input  wire logic [31:0]      ram_rdata_i
);

  walk_state_e          state_q, state_d;
  logic [31:0]          va_q, va_d;
  result_t              res_q, res_d;
  logic                 out_vld_q, out_vld_d;
  logic                 res_load;
  logic                 accept;
  logic [WordIdxW-1:0]  idx_sel;
  logic                 idx_ok;

  assign req.ready = (state_q == WS_IDLE) && (!out_vld_q || rsp.ready);
  assign accept    = req.valid && req.ready;

  // shared index path: word write, directory, then table
  always_comb begin
    unique case (state_q)
      WS_IDLE: begin
        if (cmd_e'(req.command) == CMD_WRITE) begin
          idx_sel = req.address[31:2];
        end else begin
          idx_sel = {dir_base_i, req.address[31:22]};
        end
      end
      WS_DIR:  idx_sel = {ram_rdata_i[31:12], va_q[21:12]};
      default: idx_sel = '0;
    endcase
  end

  assign idx_ok      = idx_sel < WordIdxW'(TableWords);
  assign ram_addr_o  = idx_sel[TableIdxW-1:0];
  assign ram_wdata_o = req.data;

  always_comb begin
    state_d  = state_q;
    va_d     = va_q;
    res_d    = res_q;
    res_load = 1'b0;
    ram_we_o = 1'b0;
    ram_re_o = 1'b0;

    unique case (state_q)
      WS_IDLE: begin
        if (accept) begin
          va_d = req.address;
          if (cmd_e'(req.command) == CMD_WRITE) begin
            ram_we_o = idx_ok;
            res_load = 1'b1;
            res_d    = '{status: idx_ok ? ST_OK : ST_RANGE,
                         physical_address: '0, entry_value: '0, big_page: 1'b0};
          end else if (idx_ok) begin
            ram_re_o = 1'b1;
            state_d  = WS_DIR;
          end else begin
            res_load = 1'b1;
            res_d    = '{status: ST_RANGE, physical_address: '0,
                         entry_value: '0, big_page: 1'b0};
          end
        end
      end

      WS_DIR: begin
        priority if (!ram_rdata_i[BitPresent]) begin
          res_load = 1'b1;
          res_d    = '{status: ST_FAULT, physical_address: '0,
                       entry_value: ram_rdata_i, big_page: 1'b0};
          state_d  = WS_IDLE;
        end else if (ram_rdata_i[BitBig]) begin
          res_load = 1'b1;
          res_d    = '{status: ST_OK,
                       physical_address: {ram_rdata_i[31:22], va_q[21:0]},
                       entry_value: ram_rdata_i, big_page: 1'b1};
          state_d  = WS_IDLE;
        end else if (idx_ok) begin
          ram_re_o = 1'b1;
          state_d  = WS_TBL;
        end else begin
          res_load = 1'b1;
          res_d    = '{status: ST_RANGE, physical_address: '0,
                       entry_value: '0, big_page: 1'b0};
          state_d  = WS_IDLE;
        end
      end

      WS_TBL: begin
        res_load = 1'b1;
        state_d  = WS_IDLE;
        if (!ram_rdata_i[BitPresent]) begin
          res_d = '{status: ST_FAULT, physical_address: '0,
                    entry_value: ram_rdata_i, big_page: 1'b0};
        end else begin
          res_d = '{status: ST_OK,
                    physical_address: {ram_rdata_i[31:12], va_q[11:0]},
                    entry_value: ram_rdata_i, big_page: 1'b0};
        end
      end

      default: state_d = WS_IDLE;
    endcase
  end

  // slot is known free from accept until the walk ends
  assign out_vld_d = res_load || (out_vld_q && !rsp.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= WS_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    va_q  <= va_d;
    res_q <= res_d;
  end

  assign rsp.valid            = out_vld_q;
  assign rsp.status           = res_q.status;
  assign rsp.physical_address = res_q.physical_address;
  assign rsp.entry_value      = res_q.entry_value;
  assign rsp.big_page         = res_q.big_page;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> (!out_vld_q || rsp.ready))
    else $error("response word overwritten before it was taken");

  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we_o && ram_re_o))
    else $error("store read and write in the same cycle");

  a_walk_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != WS_IDLE) |-> !out_vld_q)
    else $error("walk running while a response is pending");

  a_tbl_after_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == WS_TBL) |-> ($past(state_q) == WS_DIR))
    else $error("table read without a directory read");

  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> (state_q == WS_IDLE && accept))
    else $error("store written outside an accepted write word");

endmodule : tlptw_ctrl
`default_nettype wire

[dv/two_level_page_table_walker_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-level page table walker testbench
// Loads directory and table words, then walks them under several directory
// bases. A directed set of words comes first, then random mappings with
// translations and noise. Every response is checked against an in-bench walk
// model, with random source gaps and sink stalls throughout.
// ----------------------------------------------------------------------------
module two_level_page_table_walker_tb;
  import tlptw_pkg::*;

  localparam int StallLimit = 4000;
  localparam int TailCycles = 20;

  typedef struct packed {
    cmd_e        command;
    logic [31:0] address;
    logic [31:0] data;
  } walk_req_t;

  logic clk;
  logic rst_n;

  tlptw_req_if req_ch ();
  tlptw_rsp_if rsp_ch ();
  tlptw_cfg_if cfg_ch ();

  two_level_page_table_walker dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch),
    .cfg_i  (cfg_ch)
  );

  // walk model, updated as words are accepted
  logic [31:0] page_words [TableWords];
  logic [19:0] walk_base;
  result_t     expected_results [$];

  // stimulus planning view: contents as they will be once queued words land
  logic [31:0] plan_words [TableWords];
  bit          plan_written [TableWords];
  logic [19:0] plan_base;
  logic [9:0]  last_slot;
  walk_req_t   pending_reqs [$];

  int unsigned reqs_planned;
  int unsigned reqs_accepted;
  int unsigned error_count;
  int unsigned idle_cycles;
  bit          req_taken;

  walk_req_t   next_req;
  result_t     want;
  int unsigned src_burst;
  int unsigned src_gap;
  int unsigned sink_left;
  int unsigned sink_hold;
  int unsigned sink_mode;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic result_t predict_walk(input walk_req_t w);
    result_t     r;
    logic [30:0] idx;
    logic [31:0] pde;
    logic [31:0] pte;
    r = '{ST_OK, 32'd0, 32'd0, 1'b0};
    if (w.command == CMD_WRITE) begin
      if (w.address[31:2] < TableWords) begin
        page_words[w.address[TableIdxW+1:2]] = w.data;
      end else begin
        r.status = ST_RANGE;
      end
      return r;
    end
    idx = {1'b0, walk_base, 10'd0} + 31'(w.address[31:22]);
    if (idx >= TableWords) begin
      r.status = ST_RANGE;
      return r;
    end
    pde = page_words[idx[TableIdxW-1:0]];
    if (!pde[BitPresent]) begin
      r.status = ST_FAULT;
      r.entry_value = pde;
      return r;
    end
    if (pde[BitBig]) begin
      r.physical_address = {pde[31:22], w.address[21:0]};
      r.entry_value = pde;
      r.big_page = 1'b1;
      return r;
    end
    idx = {1'b0, pde[31:12], 10'd0} + 31'(w.address[21:12]);
    if (idx >= TableWords) begin
      r.status = ST_RANGE;
      return r;
    end
    pte = page_words[idx[TableIdxW-1:0]];
    r.entry_value = pte;
    if (!pte[BitPresent]) begin
      r.status = ST_FAULT;
    end else begin
      r.physical_address = {pte[31:12], w.address[11:0]};
    end
    return r;
  endfunction

  task automatic plan_write(input logic [31:0] addr, input logic [31:0] wdata);
    walk_req_t w;
    w.command = CMD_WRITE;
    w.address = addr;
    w.data = wdata;
    pending_reqs.push_back(w);
    reqs_planned++;
    if (addr[31:2] < TableWords) begin
      plan_words[addr[TableIdxW+1:2]] = wdata;
      plan_written[addr[TableIdxW+1:2]] = 1'b1;
    end
  endtask

  // queues a translate only if its walk reads no word left unwritten
  task automatic plan_xlate(input logic [31:0] va);
    walk_req_t   w;
    logic [30:0] idx;
    logic [31:0] pde;
    bit          legal;
    legal = 1'b1;
    idx = {1'b0, plan_base, 10'd0} + 31'(va[31:22]);
    if (idx < TableWords) begin
      if (!plan_written[idx[TableIdxW-1:0]]) begin
        legal = 1'b0;
      end else begin
        pde = plan_words[idx[TableIdxW-1:0]];
        if (pde[BitPresent] && !pde[BitBig]) begin
          idx = {1'b0, pde[31:12], 10'd0} + 31'(va[21:12]);
          if (idx < TableWords && !plan_written[idx[TableIdxW-1:0]]) legal = 1'b0;
        end
      end
    end
    if (legal) begin
      w.command = CMD_XLATE;
      w.address = va;
      w.data = $urandom();
      pending_reqs.push_back(w);
      reqs_planned++;
    end
  endtask

  // directory entry (if the base is in the store), optional table entry, then a few walks through them
  task automatic plan_mapping();
    logic [9:0]  d;
    logic [9:0]  t;
    logic [31:0] pde;
    logic [31:0] pte;
    int          n;
    d = 10'($urandom());
    t = 10'($urandom());
    pde = $urandom();
    case ($urandom_range(9))
      0, 1: begin
        pde[BitPresent] = 1'b1;
        pde[BitBig] = 1'b1;
      end
      2: pde[BitPresent] = 1'b0;
      3: begin
        pde[BitPresent] = 1'b1;
        pde[BitBig] = 1'b0;
        if (pde[31:14] == '0) pde[31] = 1'b1;  // table frame past the store
      end
      default: begin
        pde[BitPresent] = 1'b1;
        pde[BitBig] = 1'b0;
        pde[31:14] = '0;
      end
    endcase
    if (plan_base < 4) plan_write({18'd0, plan_base[1:0], d, 2'($urandom())}, pde);
    if (pde[BitPresent] && !pde[BitBig] && pde[31:14] == '0) begin
      pte = $urandom();
      pte[BitPresent] = ($urandom_range(7) != 0);
      plan_write({18'd0, pde[13:12], t, 2'($urandom())}, pte);
    end
    n = $urandom_range(1, 3);
    repeat (n) begin
      if ($urandom_range(3) == 0) t = 10'($urandom());
      plan_xlate({d, t, 12'($urandom())});
    end
    last_slot = d;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (reqs_accepted != reqs_planned || expected_results.size() != 0);
  endtask

  // called on a falling edge with the block idle
  task automatic write_base(input logic [19:0] frame);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= frame;
    do @(posedge clk);
    while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    plan_base = frame;
  endtask

  // request source: bursts of words with gaps between them
  always @(negedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_taken) begin
      if (src_gap != 0) begin
        req_ch.valid <= 1'b0;
        src_gap--;
      end else if (pending_reqs.size() != 0) begin
        next_req = pending_reqs.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.command <= next_req.command;
        req_ch.address <= next_req.address;
        req_ch.data <= next_req.data;
        if (src_burst != 0) begin
          src_burst--;
        end else begin
          src_burst = $urandom_range(0, 20);
          src_gap = ($urandom_range(3) == 0) ? $urandom_range(1, 20) : $urandom_range(0, 3);
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // response sink: stall pattern draws a new random mode whenever its mode counter runs out
  always @(negedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (sink_left == 0) begin
        sink_mode = $urandom_range(3);
        sink_left = 128;
      end
      sink_left--;
      case (sink_mode)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= 1'($urandom_range(1));
        2: rsp_ch.ready <= (sink_left[1:0] == 2'd0);
        default: begin
          if (sink_hold == 0) begin
            rsp_ch.ready <= 1'b1;
            sink_hold = $urandom_range(12);
          end else begin
            rsp_ch.ready <= 1'b0;
            sink_hold--;
          end
        end
      endcase
    end
  end

  // monitor: predicts on accepted requests, checks responses, runs watchdog
  always @(posedge clk) begin
    req_taken <= req_ch.valid && req_ch.ready;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) walk_base = cfg_ch.data;
      if (req_ch.valid && req_ch.ready) begin
        next_req.command = cmd_e'(req_ch.command);
        next_req.address = req_ch.address;
        next_req.data = req_ch.data;
        expected_results.push_back(predict_walk(next_req));
        reqs_accepted++;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_results.size() == 0) begin
          error_count++;
          if (error_count <= 10) begin
            $display("unexpected response word: status %0d pa %h entry %h big %0b",
                     rsp_ch.status, rsp_ch.physical_address, rsp_ch.entry_value,
                     rsp_ch.big_page);
          end
        end else begin
          want = expected_results.pop_front();
          if (rsp_ch.status !== want.status ||
              rsp_ch.physical_address !== want.physical_address ||
              rsp_ch.entry_value !== want.entry_value ||
              rsp_ch.big_page !== want.big_page) begin
            error_count++;
            if (error_count <= 10) begin
              $display("mismatch at %0t: status %0d/%0d pa %h/%h entry %h/%h big %0b/%0b",
                       $realtime, want.status, rsp_ch.status, want.physical_address,
                       rsp_ch.physical_address, want.entry_value, rsp_ch.entry_value,
                       want.big_page, rsp_ch.big_page);
            end
          end
        end
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= StallLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int          p;
    int unsigned phase_end;
    logic [19:0] frame;
    clk = 1'b0;
    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.command = CMD_WRITE;
    req_ch.address = '0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    walk_base = '0;
    plan_base = '0;
    last_slot = '0;
    reqs_planned = 0;
    reqs_accepted = 0;
    error_count = 0;
    idle_cycles = 0;
    req_taken = 1'b0;
    src_burst = 0;
    src_gap = 0;
    sink_left = 0;
    sink_hold = 0;
    sink_mode = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: directory at frame 1, tables at frames 2, 3 and 5
    write_base(20'd1);
    plan_write(32'h0000_0000, 32'h0000_0000);
    plan_write(32'h0000_3FFF, 32'hFFFF_FFFF);   // last store word
    plan_write(32'h0000_4000, 32'h1234_5678);   // first word past the store
    plan_write(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    plan_write(32'h0000_1000, 32'h0000_2001);
    plan_write(32'h0000_2000, 32'hABCD_E003);
    plan_xlate(32'h0000_0FFF);
    plan_write(32'h0000_2FFF, 32'hFFFF_F000);   // table entry not present
    plan_xlate(32'h003F_F123);
    plan_write(32'h0000_1FFC, 32'hFFC0_0081);   // 4 MB page at the top slot
    plan_xlate(32'hFFFF_FFFF);
    plan_write(32'h0000_1004, 32'h0000_0000);
    plan_xlate(32'h0040_0000);
    plan_write(32'h0000_1008, 32'h0000_5001);   // table beyond the store
    plan_xlate(32'h0080_0ABC);
    plan_write(32'h0000_100C, 32'hFFFF_FFFE);   // big bit but not present
    plan_xlate(32'h00C0_0000);
    plan_write(32'h0000_1010, 32'h0000_0081);
    plan_xlate(32'h013F_FFFF);
    plan_write(32'h0000_1014, 32'h0000_3001);
    plan_xlate(32'h017F_FABC);

    for (p = 0; p < 9; p++) begin
      wait_idle();
      case (p)
        0, 7: frame = 20'd0;
        1: frame = 20'hFFFFF;
        2: frame = 20'd3;
        3: frame = 20'd2;
        4: frame = 20'd4;
        5: frame = 20'd1;
        6: frame = 20'($urandom());
        default: frame = 20'($urandom_range(3));
      endcase
      write_base(frame);
      phase_end = reqs_planned + ((frame < 4) ? 300 : 40);
      while (reqs_planned < phase_end) begin
        case ($urandom_range(19))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: plan_mapping();
          11, 12, 13, 14, 15: begin
            next_req.address = $urandom();
            if ($urandom_range(3) != 0) next_req.address[31:22] = last_slot;
            plan_xlate(next_req.address);
          end
          default: begin
            if ($urandom_range(1) == 0) begin
              plan_write($urandom(), $urandom());
            end else begin
              plan_write({18'd0, 12'($urandom()), 2'($urandom())}, $urandom());
            end
          end
        endcase
      end
    end

    wait_idle();
    repeat (TailCycles) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule : two_level_page_table_walker_tb
